FILE: rtl/lrdv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lrdv_pkg
// shared types and constants for the log record deframer and verifier
// ----------------------------------------------------------------------------
package lrdv_pkg;

    localparam int unsigned HDR_BYTES   = 16;
    localparam int unsigned HDR_IDX_W   = 4;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned SEQ_W       = 64;
    localparam int unsigned LEN_W       = 16;
    localparam logic [SUM_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // header layout, byte offsets
    localparam logic [HDR_IDX_W-1:0] HDR_CSUM_OFS = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HDR_SEQ_OFS  = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HDR_KLEN_OFS = 4'd12;
    localparam logic [HDR_IDX_W-1:0] HDR_VLEN_OFS = 4'd14;
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 4'(HDR_BYTES - 1);

    typedef enum logic [3:0] {
        PH_HEADER  = 4'b0001,
        PH_KEY     = 4'b0010,
        PH_VALUE   = 4'b0100,
        PH_DISCARD = 4'b1000
    } phase_t;

    typedef logic [1:0] role_t;
    localparam role_t ROLE_HEADER  = 2'd0;
    localparam role_t ROLE_KEY     = 2'd1;
    localparam role_t ROLE_VALUE   = 2'd2;
    localparam role_t ROLE_DISCARD = 2'd3;

endpackage
`default_nettype wire

FILE: rtl/log_record_deframer_verify_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// log_record_deframer_verify_top
// deframes a byte-wide log stream, tags each byte and checks each record
//
// input channel s_*: one log byte per beat, s_final_byte marks the last byte
// of the file. output channel m_*: one result beat per input beat, carrying
// the byte, its role, the record flags and the header fields decoded so far.
// result: registered; it appears in the cycle after its input beat is accepted.
// throughput: one byte per cycle; the parser state and the result register
// are updated in the same cycle, so a new beat is taken every cycle while the
// receiver keeps taking results.
// stall: when m_ready is low the result register holds its beat and s_ready
// drops; it rises again in the cycle the waiting result is taken.
// reset (aresetn low, synchronous): parser back to the header phase, all
// record fields, record count and highest sequence cleared, no result pending.
// after a final byte the parser and record count restart; the highest
// sequence number is kept.
// ----------------------------------------------------------------------------
module log_record_deframer_verify_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_log_byte,
    input  wire logic        s_final_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_byte_role,
    output logic [7:0]       m_byte_out,
    output logic             m_record_good,
    output logic             m_record_corrupt,
    output logic             m_partial_at_end,
    output logic [63:0]      m_record_sequence,
    output logic [15:0]      m_key_length,
    output logic [15:0]      m_value_length,
    output logic [31:0]      m_records_accepted,
    output logic [63:0]      m_highest_sequence
);
    import lrdv_pkg::*;

    // parser state
    phase_t                 phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]       csum_reg, csum_next;
    logic [SEQ_W-1:0]       seq_reg, seq_next;
    logic [LEN_W-1:0]       klen_reg, klen_next;
    logic [LEN_W-1:0]       vlen_reg, vlen_next;
    logic [LEN_W-1:0]       rem_reg, rem_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SUM_W-1:0]       cnt_reg, cnt_next;
    logic [SEQ_W-1:0]       max_reg, max_next;

    // result register
    logic                   out_valid_reg;
    role_t                  role_reg;
    logic [7:0]             byte_reg;
    logic                   good_reg, corrupt_reg, partial_reg;
    logic [SEQ_W-1:0]       oseq_reg;
    logic [LEN_W-1:0]       oklen_reg, ovlen_reg;
    logic [SUM_W-1:0]       ocnt_reg;
    logic [SEQ_W-1:0]       omax_reg;

    // combinational step
    role_t                  role;
    phase_t                 phase_step;
    logic [HDR_IDX_W-1:0]   idx_step;
    logic [SEQ_W-1:0]       seq_step;
    logic [LEN_W-1:0]       klen_step, vlen_step, rem_step, rem_dec;
    logic [SUM_W-1:0]       csum_step, sum_step, calc;
    logic                   done, good, corrupt, partial;
    logic                   accept;

    assign accept  = s_valid && s_ready;
    assign s_ready = !out_valid_reg || m_ready;
    assign rem_dec = rem_reg - LEN_W'(1);

    always_comb begin
        role       = ROLE_DISCARD;
        phase_step = phase_reg;
        idx_step   = idx_reg;
        csum_step  = csum_reg;
        seq_step   = seq_reg;
        klen_step  = klen_reg;
        vlen_step  = vlen_reg;
        rem_step   = rem_reg;
        sum_step   = sum_reg;
        done       = 1'b0;
        unique case (phase_reg)
            PH_HEADER: begin
                role = ROLE_HEADER;
                if (idx_reg == HDR_CSUM_OFS) begin
                    csum_step = '0;
                    seq_step  = '0;
                    klen_step = '0;
                    vlen_step = '0;
                    sum_step  = '0;
                end
                for (int k = 0; k < 4; k++) begin
                    if (idx_reg == HDR_CSUM_OFS + HDR_IDX_W'(k)) begin
                        csum_step[8*k +: 8] = s_log_byte;
                    end
                end
                for (int k = 0; k < 8; k++) begin
                    if (idx_reg == HDR_SEQ_OFS + HDR_IDX_W'(k)) begin
                        seq_step[8*k +: 8] = s_log_byte;
                    end
                end
                for (int k = 0; k < 2; k++) begin
                    if (idx_reg == HDR_KLEN_OFS + HDR_IDX_W'(k)) begin
                        klen_step[8*k +: 8] = s_log_byte;
                    end
                    if (idx_reg == HDR_VLEN_OFS + HDR_IDX_W'(k)) begin
                        vlen_step[8*k +: 8] = s_log_byte;
                    end
                end
                if (idx_reg == HDR_LAST_IDX) begin
                    idx_step = '0;
                    if (klen_step != '0) begin
                        phase_step = PH_KEY;
                        rem_step   = klen_step;
                    end else if (vlen_step != '0) begin
                        phase_step = PH_VALUE;
                        rem_step   = vlen_step;
                    end else begin
                        done = 1'b1;
                    end
                end else begin
                    idx_step = idx_reg + HDR_IDX_W'(1);
                end
            end
            PH_KEY: begin
                role     = ROLE_KEY;
                sum_step = sum_reg + SUM_W'(s_log_byte);
                rem_step = rem_dec;
                if (rem_dec == '0) begin
                    if (vlen_reg != '0) begin
                        phase_step = PH_VALUE;
                        rem_step   = vlen_reg;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                role     = ROLE_VALUE;
                sum_step = sum_reg + SUM_W'(s_log_byte);
                rem_step = rem_dec;
                if (rem_dec == '0) begin
                    done = 1'b1;
                end
            end
            PH_DISCARD: begin
                role = ROLE_DISCARD;
            end
            default: begin
                role = ROLE_DISCARD;
            end
        endcase

        calc     = (seq_step[31:0] ^ seq_step[63:32]) + sum_step;
        good     = done && (calc == csum_step);
        corrupt  = done && (calc != csum_step);
        partial  = s_final_byte && !done && (role != ROLE_DISCARD);

        cnt_next = cnt_reg;
        max_next = max_reg;
        if (good) begin
            if (cnt_reg != COUNT_MAX) begin
                cnt_next = cnt_reg + SUM_W'(1);
            end
            if (seq_step > max_reg) begin
                max_next = seq_step;
            end
            phase_step = PH_HEADER;
            idx_step   = '0;
        end else if (corrupt) begin
            phase_step = PH_DISCARD;
        end

        phase_next = phase_step;
        idx_next   = idx_step;
        csum_next  = csum_step;
        seq_next   = seq_step;
        klen_next  = klen_step;
        vlen_next  = vlen_step;
        rem_next   = rem_step;
        sum_next   = sum_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            idx_reg   <= '0;
            csum_reg  <= '0;
            seq_reg   <= '0;
            klen_reg  <= '0;
            vlen_reg  <= '0;
            rem_reg   <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            max_reg   <= '0;
        end else if (accept) begin
            max_reg <= max_next;
            if (s_final_byte) begin
                // restart for the next file
                phase_reg <= PH_HEADER;
                idx_reg   <= '0;
                csum_reg  <= '0;
                seq_reg   <= '0;
                klen_reg  <= '0;
                vlen_reg  <= '0;
                rem_reg   <= '0;
                sum_reg   <= '0;
                cnt_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                idx_reg   <= idx_next;
                csum_reg  <= csum_next;
                seq_reg   <= seq_next;
                klen_reg  <= klen_next;
                vlen_reg  <= vlen_next;
                rem_reg   <= rem_next;
                sum_reg   <= sum_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            role_reg    <= role;
            byte_reg    <= s_log_byte;
            good_reg    <= good;
            corrupt_reg <= corrupt;
            partial_reg <= partial;
            oseq_reg    <= seq_next;
            oklen_reg   <= klen_next;
            ovlen_reg   <= vlen_next;
            ocnt_reg    <= cnt_next;
            omax_reg    <= max_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_byte_role        = role_reg;
    assign m_byte_out         = byte_reg;
    assign m_record_good      = good_reg;
    assign m_record_corrupt   = corrupt_reg;
    assign m_partial_at_end   = partial_reg;
    assign m_record_sequence  = oseq_reg;
    assign m_key_length       = oklen_reg;
    assign m_value_length     = ovlen_reg;
    assign m_records_accepted = ocnt_reg;
    assign m_highest_sequence = omax_reg;

    // checks
    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_valid)
        else $error("accepted beat produced no result");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_record_good && m_record_corrupt)
                    && !(m_partial_at_end && (m_record_good || m_record_corrupt)))
        else $error("record flags not exclusive");

    a_discard_no_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_role == ROLE_DISCARD)
            |-> !m_record_good && !m_record_corrupt && !m_partial_at_end)
        else $error("flag raised on a discarded byte");

    a_highest_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && $past(aresetn)) |=> (max_reg >= $past(max_reg)))
        else $error("highest sequence decreased");

endmodule
`default_nettype wire

FILE: bench/tb_log_record_deframer_verify_top.sv
// ----------------------------------------------------------------------------
// tb_log_record_deframer_verify_top
// self-checking bench for the log record deframer and verifier
//
// builds log files from records with correct or damaged checksums, adds noise
// and cuts files short, then plays them byte by byte through the input
// channel. every accepted byte runs through a bit-accurate model of the parser
// and the predicted beat is queued; each result beat is checked field by
// field against the oldest prediction. both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb_log_record_deframer_verify_top;
    import lrdv_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          DRAIN_LIMIT = 2000;

    typedef struct {
        role_t       role;
        logic [7:0]  data;
        logic        good;
        logic        corrupt;
        logic        partial;
        logic [63:0] seq;
        logic [15:0] key_len;
        logic [15:0] value_len;
        logic [31:0] accepted;
        logic [63:0] highest;
    } byte_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_log_byte;
    logic        s_final_byte;
    logic        m_valid;
    logic        m_ready;
    logic [1:0]  m_byte_role;
    logic [7:0]  m_byte_out;
    logic        m_record_good;
    logic        m_record_corrupt;
    logic        m_partial_at_end;
    logic [63:0] m_record_sequence;
    logic [15:0] m_key_length;
    logic [15:0] m_value_length;
    logic [31:0] m_records_accepted;
    logic [63:0] m_highest_sequence;

    // parser model state
    phase_t                 lg_phase;
    logic [HDR_IDX_W-1:0]   hdr_pos;
    logic [31:0]            hdr_checksum;
    logic [63:0]            hdr_sequence;
    logic [15:0]            hdr_key_len;
    logic [15:0]            hdr_value_len;
    logic [15:0]            payload_left;
    logic [31:0]            payload_sum;
    logic [31:0]            good_records;
    logic [63:0]            top_sequence;

    byte_result_t pending_byte_results[$];
    byte_result_t oldest_result;
    logic [7:0]   log_file[$];
    int           gap_max;
    int           stall_max;
    int           fail_count;
    int unsigned  cycle_count = 0;

    log_record_deframer_verify_top DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_log_byte         (s_log_byte),
        .s_final_byte       (s_final_byte),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_byte_role        (m_byte_role),
        .m_byte_out         (m_byte_out),
        .m_record_good      (m_record_good),
        .m_record_corrupt   (m_record_corrupt),
        .m_partial_at_end   (m_partial_at_end),
        .m_record_sequence  (m_record_sequence),
        .m_key_length       (m_key_length),
        .m_value_length     (m_value_length),
        .m_records_accepted (m_records_accepted),
        .m_highest_sequence (m_highest_sequence)
    );

    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    function automatic void restart_log_parser();
        lg_phase      = PH_HEADER;
        hdr_pos       = '0;
        hdr_checksum  = '0;
        hdr_sequence  = '0;
        hdr_key_len   = '0;
        hdr_value_len = '0;
        payload_left  = '0;
        payload_sum   = '0;
    endfunction

    function automatic byte_result_t deframe_byte(input logic [7:0] b, input logic last);
        byte_result_t r;
        logic         finished;
        int           pos;
        logic [31:0]  calc;
        finished = 1'b0;
        r.role   = ROLE_DISCARD;
        r.good    = 1'b0;
        r.corrupt = 1'b0;
        case (lg_phase)
            PH_HEADER: begin
                r.role = ROLE_HEADER;
                pos    = int'(hdr_pos);
                if (hdr_pos == HDR_CSUM_OFS) begin
                    hdr_checksum  = '0;
                    hdr_sequence  = '0;
                    hdr_key_len   = '0;
                    hdr_value_len = '0;
                    payload_sum   = '0;
                end
                if (pos < int'(HDR_SEQ_OFS))
                    hdr_checksum |= 32'(b) << (8 * pos);
                else if (pos < int'(HDR_KLEN_OFS))
                    hdr_sequence |= 64'(b) << (8 * (pos - int'(HDR_SEQ_OFS)));
                else if (pos < int'(HDR_VLEN_OFS))
                    hdr_key_len |= 16'(b) << (8 * (pos - int'(HDR_KLEN_OFS)));
                else
                    hdr_value_len |= 16'(b) << (8 * (pos - int'(HDR_VLEN_OFS)));
                if (hdr_pos == HDR_LAST_IDX) begin
                    hdr_pos = '0;
                    if (hdr_key_len != 0) begin
                        lg_phase     = PH_KEY;
                        payload_left = hdr_key_len;
                    end else if (hdr_value_len != 0) begin
                        lg_phase     = PH_VALUE;
                        payload_left = hdr_value_len;
                    end else begin
                        finished = 1'b1;
                    end
                end else begin
                    hdr_pos = hdr_pos + 1'b1;
                end
            end
            PH_KEY: begin
                r.role       = ROLE_KEY;
                payload_sum  = payload_sum + 32'(b);
                payload_left = payload_left - 1'b1;
                if (payload_left == 0) begin
                    if (hdr_value_len != 0) begin
                        lg_phase     = PH_VALUE;
                        payload_left = hdr_value_len;
                    end else begin
                        finished = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                r.role       = ROLE_VALUE;
                payload_sum  = payload_sum + 32'(b);
                payload_left = payload_left - 1'b1;
                if (payload_left == 0)
                    finished = 1'b1;
            end
            default: ;
        endcase

        if (finished) begin
            calc = (hdr_sequence[31:0] ^ hdr_sequence[63:32]) + payload_sum;
            if (calc == hdr_checksum) begin
                r.good = 1'b1;
                if (good_records != COUNT_MAX)
                    good_records = good_records + 1'b1;
                if (hdr_sequence > top_sequence)
                    top_sequence = hdr_sequence;
                lg_phase = PH_HEADER;
                hdr_pos  = '0;
            end else begin
                r.corrupt = 1'b1;
                lg_phase  = PH_DISCARD;
            end
        end

        r.data      = b;
        r.partial   = last && !finished && (r.role != ROLE_DISCARD);
        r.seq       = hdr_sequence;
        r.key_len   = hdr_key_len;
        r.value_len = hdr_value_len;
        r.accepted  = good_records;
        r.highest   = top_sequence;

        if (last) begin
            restart_log_parser();
            good_records = '0;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] expv,
                                        input logic [63:0] actv);
        if (actv !== expv) begin
            $error("%s: expected %0h, got %0h", name, expv, actv);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                pending_byte_results.push_back(deframe_byte(s_log_byte, s_final_byte));
            if (m_valid && m_ready) begin
                if (pending_byte_results.size() == 0) begin
                    $error("result beat with no byte outstanding");
                    fail_count++;
                end else begin
                    oldest_result = pending_byte_results.pop_front();
                    check_field("byte_role", 64'(oldest_result.role), 64'(m_byte_role));
                    check_field("byte_out", 64'(oldest_result.data), 64'(m_byte_out));
                    check_field("record_good", 64'(oldest_result.good), 64'(m_record_good));
                    check_field("record_corrupt", 64'(oldest_result.corrupt),
                                64'(m_record_corrupt));
                    check_field("partial_at_end", 64'(oldest_result.partial),
                                64'(m_partial_at_end));
                    check_field("record_sequence", oldest_result.seq, m_record_sequence);
                    check_field("key_length", 64'(oldest_result.key_len), 64'(m_key_length));
                    check_field("value_length", 64'(oldest_result.value_len),
                                64'(m_value_length));
                    check_field("records_accepted", 64'(oldest_result.accepted),
                                64'(m_records_accepted));
                    check_field("highest_sequence", oldest_result.highest,
                                m_highest_sequence);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_log_record_deframer_verify_top NOT OK");
            $finish;
        end
    end

    // result side back-pressure
    initial begin : result_pacing
        int hold;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            hold = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
            if (hold > 0) begin
                m_ready = 1'b0;
                repeat (hold) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    // called at a falling edge, returns at the falling edge after the beat
    task automatic send_log_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      = 1'b1;
        s_log_byte   = b;
        s_final_byte = last;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic send_log_file();
        for (int i = 0; i < log_file.size(); i++)
            send_log_byte(log_file[i], i == log_file.size() - 1);
        log_file.delete();
    endtask

    // fill below zero means random payload bytes
    task automatic add_record(input logic [63:0] seq, input logic [15:0] klen,
                              input logic [15:0] vlen, input bit bad, input int fill);
        logic [7:0]  body[$];
        logic [31:0] csum;
        logic [7:0]  v;
        int          total;
        total = int'(klen) + int'(vlen);
        csum  = seq[31:0] ^ seq[63:32];
        for (int i = 0; i < total; i++) begin
            v = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
            body.push_back(v);
            csum = csum + 32'(v);
        end
        if (bad)
            csum = csum ^ (32'd1 << $urandom_range(0, 31));
        for (int i = 0; i < 4; i++) log_file.push_back(csum[8*i +: 8]);
        for (int i = 0; i < 8; i++) log_file.push_back(seq[8*i +: 8]);
        for (int i = 0; i < 2; i++) log_file.push_back(klen[8*i +: 8]);
        for (int i = 0; i < 2; i++) log_file.push_back(vlen[8*i +: 8]);
        foreach (body[i]) log_file.push_back(body[i]);
    endtask

    task automatic add_noise(input int n);
        repeat (n) log_file.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic cut_log_file(input int n);
        repeat (n) void'(log_file.pop_back());
    endtask

    function automatic logic [63:0] random_sequence();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 100));
            1:       return {32'($urandom), 32'($urandom)};
            2:       return {32'd0, 32'($urandom)};
            default: return {32'($urandom_range(0, 3)), 32'($urandom)};
        endcase
    endfunction

    function automatic logic [15:0] random_length();
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            7:       return 16'($urandom_range(9, 40));
            default: return 16'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic test_empty_payloads();
        gap_max   = 2;
        stall_max = 2;
        add_record(64'd5, 16'd0, 16'd0, 1'b0, -1);
        add_record(64'd9, 16'd0, 16'd3, 1'b0, -1);
        add_record(64'd7, 16'd2, 16'd0, 1'b0, -1);
        add_record(64'd11, 16'd1, 16'd1, 1'b0, -1);
        add_record(64'd3, 16'd0, 16'd0, 1'b0, -1);
        send_log_file();
    endtask

    task automatic test_corrupt_and_discard();
        gap_max   = 3;
        stall_max = 0;
        add_record(64'd100, 16'd2, 16'd2, 1'b0, -1);
        add_record(64'd200, 16'd0, 16'd0, 1'b1, -1);
        add_record(64'd300, 16'd1, 16'd1, 1'b0, -1);
        add_noise(3);
        send_log_file();
        add_record(64'd50, 16'd1, 16'd2, 1'b0, -1);
        add_record(64'd150, 16'd3, 16'd0, 1'b1, -1);
        send_log_file();
        add_record(64'd60, 16'd0, 16'd2, 1'b1, -1);
        add_noise(1);
        send_log_file();
    endtask

    task automatic test_truncated_logs();
        gap_max   = 0;
        stall_max = 3;
        add_noise(1);
        send_log_file();
        add_record(64'd400, 16'd1, 16'd1, 1'b0, -1);
        add_noise(1);
        send_log_file();
        add_record(64'd77, 16'd4, 16'd4, 1'b0, -1);
        cut_log_file(8);
        send_log_file();
        add_record(64'd78, 16'd2, 16'd2, 1'b0, -1);
        cut_log_file(log_file.size() - 9);
        send_log_file();
        add_record(64'd79, 16'd3, 16'd2, 1'b0, -1);
        cut_log_file(2);
        send_log_file();
        add_record(64'd80, 16'd0, 16'd5, 1'b0, -1);
        cut_log_file(1);
        send_log_file();
    endtask

    task automatic test_field_extremes();
        gap_max   = 5;
        stall_max = 5;
        add_record(64'hFFFF_FFFF_FFFF_FFFF, 16'd1, 16'd1, 1'b1, 8'hFF);
        add_noise(2);
        send_log_file();
        add_record(64'd0, 16'd1, 16'd1, 1'b0, 8'h00);
        add_record(64'hFFFF_FFFF_0000_0000, 16'd4, 16'd4, 1'b0, 8'hFF);
        add_record(64'h8000_0000_0000_0001, 16'd0, 16'd1, 1'b0, 8'h80);
        add_record(64'h0000_0001_FFFF_FFFE, 16'd2, 16'd0, 1'b0, 8'h7F);
        send_log_file();
    endtask

    // key length with the upper length byte set
    task automatic test_long_record();
        gap_max   = 0;
        stall_max = 0;
        add_record(64'h0123_4567_89AB_CDEF, 16'h0100, 16'h0001, 1'b0, -1);
        add_record(64'd12, 16'd1, 16'd0, 1'b0, -1);
        send_log_file();
    endtask

    task automatic test_random_logs();
        int sent;
        int kind;
        int keep;
        sent = 0;
        while (sent < 200) begin
            if ($urandom_range(0, 4) == 0) begin
                gap_max   = 0;
                stall_max = 0;
            end else begin
                gap_max   = $urandom_range(0, 5);
                stall_max = $urandom_range(0, 5);
            end
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                add_noise($urandom_range(1, 40));
            end else if (kind == 3) begin
                // long lengths in the header, file ends early
                add_record(random_sequence(), 16'($urandom), 16'($urandom), 1'b0, -1);
                keep = 16 + $urandom_range(0, 8);
                cut_log_file(log_file.size() - keep);
            end else begin
                repeat ($urandom_range(1, 4))
                    add_record(random_sequence(), random_length(), random_length(),
                               $urandom_range(0, 7) == 0, -1);
                if (kind == 1)
                    add_noise($urandom_range(1, 3));
                else if (kind == 2)
                    cut_log_file($urandom_range(1, log_file.size() - 1));
            end
            sent += log_file.size();
            send_log_file();
        end
        gap_max   = 2;
        stall_max = 2;
        add_record(64'hFFFF_FFFF_FFFF_FFFF, 16'd2, 16'd3, 1'b0, -1);
        add_record(64'd5, 16'd1, 16'd0, 1'b0, -1);
        send_log_file();
    endtask

    initial begin : main_sequence
        int drain_wait;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_log_byte   = 8'h00;
        s_final_byte = 1'b0;
        gap_max      = 0;
        stall_max    = 0;
        fail_count   = 0;
        restart_log_parser();
        good_records = '0;
        top_sequence = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_payloads();
        test_corrupt_and_discard();
        test_truncated_logs();
        test_field_extremes();
        test_long_record();
        test_random_logs();

        s_valid    = 1'b0;
        drain_wait = 0;
        while (pending_byte_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        if (pending_byte_results.size() != 0) begin
            $error("%0d expected result beats never arrived", pending_byte_results.size());
            fail_count++;
        end
        repeat (4) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_log_record_deframer_verify_top OK");
        else
            $display("tb_log_record_deframer_verify_top NOT OK");
        $finish;
    end

endmodule

FILE: log_record_deframer_verify_top.f
rtl/lrdv_pkg.sv
rtl/log_record_deframer_verify_top.sv
bench/tb_log_record_deframer_verify_top.sv
